### sv/rainbow_pixel_color_generator_macros.svh
// assertion macros for the rainbow pixel color generator
`ifndef RAINBOW_PIXEL_COLOR_GENERATOR_MACROS_SVH
`define RAINBOW_PIXEL_COLOR_GENERATOR_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RPCG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define RPCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rpcg_pkg.sv
// shared types, constants and helpers for the rainbow pixel color generator
package rpcg_pkg;

    // hue wheel geometry
    localparam int unsigned HueCycle    = 1536;
    localparam int unsigned PeriodBits  = 5;
    localparam int unsigned HueW        = 11;
    localparam logic [HueW-1:0] HUE_CYCLE = HueW'(HueCycle);

    // channel levels
    localparam logic [7:0] FULL        = 8'd255;
    localparam logic [7:0] PASTEL_BASE = 8'd64;

    // configuration register indexes
    localparam logic [1:0] CFG_STRIP_OFFSET = 2'd0;
    localparam logic [1:0] CFG_REVERSE      = 2'd1;
    localparam logic [1:0] CFG_PASTEL       = 2'd2;

    // color wheel sectors
    localparam logic [2:0] SECTOR_RED_GREEN_UP  = 3'd0;
    localparam logic [2:0] SECTOR_RED_DOWN      = 3'd1;
    localparam logic [2:0] SECTOR_BLUE_UP       = 3'd2;
    localparam logic [2:0] SECTOR_GREEN_DOWN    = 3'd3;
    localparam logic [2:0] SECTOR_RED_UP        = 3'd4;
    localparam logic [2:0] SECTOR_BLUE_DOWN     = 3'd5;

    // pixel request payload
    typedef struct packed {
        logic [7:0]  strip_index;
        logic [15:0] led_index;
        logic [10:0] hue_motion;
    } pixel_t;

    // pixel color payload
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // pastel compression: 64 + floor(3c/4)
    function automatic logic [7:0] soften(input logic [7:0] c);
        logic [9:0] triple;
        triple = {2'b00, c} + {1'b0, c, 1'b0};
        return PASTEL_BASE + triple[9:2];
    endfunction

endpackage

### sv/rainbow_pixel_color_generator.sv
// top level of the rainbow pixel color generator
`include "rainbow_pixel_color_generator_macros.svh"

// Takes one pixel request per clock on start and returns its RGB color as a
// one-cycle pulse on done with the color on the color port. The request is
// captured in an input register, the hue and color wheel logic runs in the
// following cycle and lands in the result register, so the rate is one pixel
// per clock. busy stays low and the receiver must take each result in the
// cycle done is high, since it cannot stall the block. Registers are written
// through the cfg channel, which is always ready; write them only while no
// request is in flight.
module rainbow_pixel_color_generator
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rpcg_pkg::pixel_t  pixel,
    output logic              done,
    output rpcg_pkg::color_t  color,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    // only the low bits of the offset reach the 32-pixel spatial phase
    logic [4:0]        offset_low_reg;
    logic              reverse_reg;
    logic              pastel_reg;

    logic              item_valid_reg;
    rpcg_pkg::pixel_t  item_reg;
    logic              done_reg;
    rpcg_pkg::color_t  color_reg;

    logic [10:0]       hue;
    rpcg_pkg::color_t  color_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_low_reg <= 5'd0;
            reverse_reg    <= 1'b0;
            pastel_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpcg_pkg::CFG_STRIP_OFFSET: offset_low_reg <= cfg_data[4:0];
                rpcg_pkg::CFG_REVERSE:      reverse_reg    <= cfg_data[0];
                rpcg_pkg::CFG_PASTEL:       pastel_reg     <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= start && !busy;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= pixel;
    end

    rpcg_hue u_hue
    (
        .pixel      (item_reg),
        .offset_low (offset_low_reg),
        .reverse    (reverse_reg),
        .hue        (hue)
    );

    rpcg_wheel u_wheel
    (
        .hue    (hue),
        .pastel (pastel_reg),
        .color  (color_next)
    );

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= item_valid_reg;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
            color_reg <= color_next;
    end

    assign done  = done_reg;
    assign color = color_reg;

    // checks
    `RPCG_ASSERT_NEXT(a_accept_to_stage, start && !busy, item_valid_reg, "accepted request lost")
    `RPCG_ASSERT_NEXT(a_stage_to_done, item_valid_reg, done, "staged request gave no result")
    `RPCG_ASSERT_IMPL(a_has_full, done, (color.red == rpcg_pkg::FULL) || (color.green == rpcg_pkg::FULL) || (color.blue == rpcg_pkg::FULL), "no saturated channel")
    `RPCG_ASSERT_IMPL(a_has_floor, done, (color.red == 8'd0) || (color.green == 8'd0) || (color.blue == 8'd0) || ((color.red >= rpcg_pkg::PASTEL_BASE) && (color.green >= rpcg_pkg::PASTEL_BASE) && (color.blue >= rpcg_pkg::PASTEL_BASE)), "color neither wheel nor pastel")

endmodule

### sv/rpcg_hue.sv
// hue computation from pixel position and motion phase
module rpcg_hue
(
    input  rpcg_pkg::pixel_t       pixel,
    input  logic [4:0]             offset_low,
    input  logic                   reverse,
    output logic [10:0]            hue
);

    logic [10:0] motion_wrap;
    logic [10:0] motion;
    logic [4:0]  phase;
    logic [11:0] spatial;
    logic [11:0] hue_sum;

    // reduce motion into the wheel, then mirror it when reversed
    always_comb
    begin
        if (pixel.hue_motion >= rpcg_pkg::HUE_CYCLE)
            motion_wrap = pixel.hue_motion - rpcg_pkg::HUE_CYCLE;
        else
            motion_wrap = pixel.hue_motion;
        if (reverse && (motion_wrap != 11'd0))
            motion = rpcg_pkg::HUE_CYCLE - motion_wrap;
        else
            motion = motion_wrap;
    end

    // spatial phase wraps every 32 pixels, only low bits of each term count
    assign phase = offset_low + pixel.strip_index[4:0] + pixel.led_index[4:0];

    // phase times 48 as two shifted copies
    assign spatial = {2'b00, phase, 5'b00000} + {3'b000, phase, 4'b0000};

    // sum lies in 1..3024, one conditional subtract brings it onto the wheel
    always_comb
    begin
        hue_sum = spatial + {1'b0, rpcg_pkg::HUE_CYCLE} - {1'b0, motion};
        if (hue_sum >= {1'b0, rpcg_pkg::HUE_CYCLE})
            hue = hue_sum[10:0] - rpcg_pkg::HUE_CYCLE;
        else
            hue = hue_sum[10:0];
    end

endmodule

### sv/rpcg_wheel.sv
// six-sector color wheel with optional pastel compression
module rpcg_wheel
(
    input  logic [10:0]        hue,
    input  logic               pastel,
    output rpcg_pkg::color_t   color
);

    logic [7:0]       ramp;
    logic [7:0]       fall;
    rpcg_pkg::color_t raw;

    assign ramp = hue[7:0];
    assign fall = rpcg_pkg::FULL - ramp;

    // sector select
    always_comb
    begin
        case (hue[10:8])
            rpcg_pkg::SECTOR_RED_GREEN_UP:
            begin
                raw = '{red: rpcg_pkg::FULL, green: ramp, blue: 8'd0};
            end
            rpcg_pkg::SECTOR_RED_DOWN:
            begin
                raw = '{red: fall, green: rpcg_pkg::FULL, blue: 8'd0};
            end
            rpcg_pkg::SECTOR_BLUE_UP:
            begin
                raw = '{red: 8'd0, green: rpcg_pkg::FULL, blue: ramp};
            end
            rpcg_pkg::SECTOR_GREEN_DOWN:
            begin
                raw = '{red: 8'd0, green: fall, blue: rpcg_pkg::FULL};
            end
            rpcg_pkg::SECTOR_RED_UP:
            begin
                raw = '{red: ramp, green: 8'd0, blue: rpcg_pkg::FULL};
            end
            default:
            begin
                raw = '{red: rpcg_pkg::FULL, green: 8'd0, blue: fall};
            end
        endcase
    end

    // pastel mapping per channel
    always_comb
    begin
        if (pastel)
        begin
            color.red   = rpcg_pkg::soften(raw.red);
            color.green = rpcg_pkg::soften(raw.green);
            color.blue  = rpcg_pkg::soften(raw.blue);
        end
        else
        begin
            color = raw;
        end
    end

endmodule

### tb/tb_top.sv
// self-checking testbench for the rainbow pixel color generator
module tb_top;
    import rpcg_pkg::*;

    // unassigned register index, writes to it must leave every setting alone
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned SpatialStep = HueCycle >> PeriodBits;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned StallLimit = 1000;
    localparam int unsigned RandomPhases = 6;
    localparam int unsigned PhaseItems = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    pixel_t      pixel = '0;
    logic        done;
    color_t      color;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_STRIP_OFFSET;
    logic [15:0] cfg_data = '0;

    // settings as the block should hold them
    logic [15:0] cur_strip_offset = '0;
    logic        cur_reverse = 1'b0;
    logic        cur_pastel = 1'b0;

    color_t      pending_colors[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    rainbow_pixel_color_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .color     (color),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // channel compression used by the pastel palette
    function automatic logic [7:0] pastel_level(input logic [7:0] c);
        int unsigned v;
        v = 64 + (int'(c) * 3) / 4;
        return v[7:0];
    endfunction

    // color of one pixel under the current settings
    function automatic color_t rainbow_color(input pixel_t p);
        logic [10:0] motion;
        logic [15:0] full_strip;
        logic [4:0]  phase;
        int unsigned hue;
        logic [2:0]  sector;
        logic [7:0]  ramp;
        logic [7:0]  fall;
        color_t      c;
        motion = (p.hue_motion >= HUE_CYCLE) ? p.hue_motion - HUE_CYCLE : p.hue_motion;
        if (cur_reverse && motion != 11'd0)
            motion = HUE_CYCLE - motion;
        full_strip = cur_strip_offset + {8'd0, p.strip_index};
        phase = full_strip[4:0] + p.led_index[4:0];
        hue = (int'(phase) * SpatialStep + HueCycle - int'(motion)) % HueCycle;
        sector = 3'(hue >> 8);
        ramp = hue[7:0];
        fall = FULL - ramp;
        case (sector)
            SECTOR_RED_GREEN_UP: c = '{FULL, ramp, 8'd0};
            SECTOR_RED_DOWN:     c = '{fall, FULL, 8'd0};
            SECTOR_BLUE_UP:      c = '{8'd0, FULL, ramp};
            SECTOR_GREEN_DOWN:   c = '{8'd0, fall, FULL};
            SECTOR_RED_UP:       c = '{ramp, 8'd0, FULL};
            default:             c = '{FULL, 8'd0, fall};
        endcase
        if (cur_pastel)
        begin
            c.red = pastel_level(c.red);
            c.green = pastel_level(c.green);
            c.blue = pastel_level(c.blue);
        end
        return c;
    endfunction

    // compare one channel and report a difference
    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // track register writes, predict accepted pixels, check each color
    always @(posedge clk)
    begin : color_check
        color_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STRIP_OFFSET: cur_strip_offset <= cfg_data;
                    CFG_REVERSE:      cur_reverse <= cfg_data[0];
                    CFG_PASTEL:       cur_pastel <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (start && !busy)
                pending_colors.push_back(rainbow_color(pixel));
            if (done)
            begin
                if (pending_colors.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: color %h arrived with no pixel outstanding, expected none",
                             $time, color);
                end
                else
                begin
                    want = pending_colors.pop_front();
                    check_channel("red", want.red, color.red);
                    check_channel("green", want.green, color.green);
                    check_channel("blue", want.blue, color.blue);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one pixel transfer; start stays high for the caller to reuse or drop
    task automatic send_pixel(input pixel_t p);
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    // sender gap
    task automatic idle_cycles(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop sending and let every color come back
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // one register transfer; valid is dropped by the caller
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [15:0] offset, input logic reverse,
                                  input logic pastel);
        wait_idle();
        write_reg(CFG_STRIP_OFFSET, offset);
        write_reg(CFG_REVERSE, {15'd0, reverse});
        write_reg(CFG_PASTEL, {15'd0, pastel});
        cfg_valid <= 1'b0;
    endtask

    // random pixels sent in bursts with random gaps
    task automatic send_stream(input int unsigned count);
        int unsigned burst_left;
        pixel_t p;
        burst_left = $urandom_range(1, 40);
        repeat (count)
        begin
            p.strip_index = 8'($urandom_range(0, 255));
            p.led_index = 16'($urandom);
            if ($urandom_range(0, 6) == 0)
                p.hue_motion = 11'($urandom_range(HueCycle, 2047));
            else
                p.hue_motion = 11'($urandom_range(0, HueCycle - 1));
            send_pixel(p);
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // reset settings: every wheel sector edge, field extremes, motion wrap
    task automatic test_wheel_sectors();
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd0});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1281});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1280});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1025});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1024});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd769});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd768});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd513});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd512});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd257});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd256});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1});
        send_pixel(pixel_t'{8'd255, 16'd65535, 11'd0});
        send_pixel(pixel_t'{8'd255, 16'd65535, 11'd1535});
        // motion past the wheel wraps back
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1536});
        send_pixel(pixel_t'{8'd7, 16'd3, 11'd2047});
        send_pixel(pixel_t'{8'h55, 16'hAAAA, 11'h555});
        send_pixel(pixel_t'{8'hAA, 16'h5555, 11'h2AA});
    endtask

    // extreme settings: mirrored motion, zero motion in reverse, strip wrap
    task automatic test_extreme_settings();
        apply_settings(16'hFFFF, 1'b1, 1'b1);
        send_pixel(pixel_t'{8'd255, 16'd0, 11'd0});
        send_pixel(pixel_t'{8'd1, 16'd31, 11'd1});
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd1535});
        send_pixel(pixel_t'{8'd3, 16'd65535, 11'd2047});
        send_pixel(pixel_t'{8'd200, 16'd100, 11'd1536});
        apply_settings(16'd0, 1'b1, 1'b0);
        send_pixel(pixel_t'{8'd0, 16'd0, 11'd0});
        send_pixel(pixel_t'{8'd9, 16'd4, 11'd700});
        apply_settings(16'h8000, 1'b0, 1'b1);
        send_pixel(pixel_t'{8'd17, 16'd12, 11'd300});
        send_pixel(pixel_t'{8'd255, 16'd65535, 11'd1100});
    endtask

    // writes to the unassigned index change nothing
    task automatic test_unused_register();
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_pixel(pixel_t'{8'd5, 16'd6, 11'd400});
        send_pixel(pixel_t'{8'd31, 16'd1, 11'd0});
        wait_idle();
        write_reg(CFG_UNUSED, 16'h0000);
        cfg_valid <= 1'b0;
        send_pixel(pixel_t'{8'd128, 16'd999, 11'd1400});
    endtask

    // random pixels under a new setting per phase, extremes first
    task automatic test_random_pixels();
        for (int unsigned ph = 0; ph < RandomPhases; ph++)
        begin
            if (ph == 0)
                apply_settings(16'd0, 1'b0, 1'b0);
            else if (ph == 1)
                apply_settings(16'hFFFF, 1'b1, 1'b1);
            else
                apply_settings(16'($urandom), 1'($urandom), 1'($urandom));
            send_stream(PhaseItems);
        end
    endtask

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_wheel_sectors();
        test_extreme_settings();
        test_unused_register();
        test_random_pixels();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_colors.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### rainbow_pixel_color_generator.f
+incdir+sv
sv/rpcg_pkg.sv
sv/rpcg_hue.sv
sv/rpcg_wheel.sv
sv/rainbow_pixel_color_generator.sv
tb/tb_top.sv
